/* rtl/core/mtpe_pkg.sv */
// Shared types and constants for the max-based tuple pairing encoder.
package mtpe_pkg;

    localparam int CODE_BITS        = 60;
    localparam int FIELD_BITS       = 15;
    localparam int FIELD_COUNT      = 4;
    localparam int LEN_FIELD_BITS   = 3;
    localparam int LEN_BITS         = 4;
    localparam int PIVOT_BITS       = 3;
    localparam int DEF_MAX_TUPLE    = 4;
    localparam int DEF_ELEMENT_BITS = 15;

    typedef struct packed {
        logic                  vld;
        logic [LEN_BITS-1:0]   len;
        logic [PIVOT_BITS-1:0] pivot;
    } mtpe_ctl_t;

endpackage

/* rtl/core/max_tuple_pairing_encode_core.sv */
// Top level of the max-based tuple pairing encoder: two cell chains and the final offset adder.
//
// The core accepts one request in every clock cycle; busy is always low. Each request
// passes through MAX_TUPLE maximum-search cells, then MAX_TUPLE accumulation cells and a
// final adder whose sum is registered into code as done rises. Results come out in request
// order, one cycle each, and the receiver must take them when done is high because the
// core cannot hold them.
module max_tuple_pairing_encode_core
    import mtpe_pkg::*;
#(
    parameter int MAX_TUPLE    = DEF_MAX_TUPLE,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [LEN_FIELD_BITS-1:0] tuple_length,
    input  logic [FIELD_BITS-1:0]     element_0,
    input  logic [FIELD_BITS-1:0]     element_1,
    input  logic [FIELD_BITS-1:0]     element_2,
    input  logic [FIELD_BITS-1:0]     element_3,
    output logic                      done,
    output logic [CODE_BITS-1:0]      code
);

    localparam int ELEMS_BITS = MAX_TUPLE * ELEMENT_BITS;
    localparam int CELLS      = 2 * MAX_TUPLE;

    logic [FIELD_BITS-1:0]   fields [FIELD_COUNT];
    mtpe_ctl_t               ctl_chain   [CELLS+1];
    logic [ELEMS_BITS-1:0]   elems_chain [CELLS+1];
    logic [ELEMENT_BITS-1:0] beta_chain  [CELLS+1];
    logic [CODE_BITS-1:0]    acc_chain    [MAX_TUPLE+1];
    logic [CODE_BITS-1:0]    pw_lo_chain  [MAX_TUPLE+1];
    logic [CODE_BITS-1:0]    pw_hi_chain  [MAX_TUPLE+1];
    logic [CODE_BITS-1:0]    pw_mix_chain [MAX_TUPLE+1];
    logic [LEN_BITS-1:0]     len_sat;
    logic [CODE_BITS-1:0]    sum;
    logic [CODE_BITS-1:0]    code_reg;
    logic [CODE_BITS-1:0]    code_next;
    logic                    done_reg;

    assign fields[0] = element_0;
    assign fields[1] = element_1;
    assign fields[2] = element_2;
    assign fields[3] = element_3;

    assign len_sat = (LEN_BITS'(tuple_length) > LEN_BITS'(MAX_TUPLE)) ?
                     LEN_BITS'(MAX_TUPLE) : LEN_BITS'(tuple_length);

    assign ctl_chain[0]  = '{vld: start, len: len_sat, pivot: '0};
    assign beta_chain[0] = '0;

    generate
        for (genvar i = 0; i < MAX_TUPLE; i++)
        begin : g_load
            if (i < FIELD_COUNT)
            begin : g_field
                assign elems_chain[0][i*ELEMENT_BITS +: ELEMENT_BITS] =
                    ELEMENT_BITS'(fields[i]);
            end
            else
            begin : g_zero
                assign elems_chain[0][i*ELEMENT_BITS +: ELEMENT_BITS] = '0;
            end
        end

        for (genvar i = 0; i < MAX_TUPLE; i++)
        begin : g_max
            mtpe_max_cell #(
                .IDX          (i),
                .MAX_TUPLE    (MAX_TUPLE),
                .ELEMENT_BITS (ELEMENT_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl_in    (ctl_chain[i]),
                .elems_in  (elems_chain[i]),
                .beta_in   (beta_chain[i]),
                .ctl_out   (ctl_chain[i+1]),
                .elems_out (elems_chain[i+1]),
                .beta_out  (beta_chain[i+1])
            );
        end
    endgenerate

    assign acc_chain[0]    = '0;
    assign pw_lo_chain[0]  = CODE_BITS'(1);
    assign pw_hi_chain[0]  = CODE_BITS'(1);
    assign pw_mix_chain[0] = CODE_BITS'(1);

    generate
        for (genvar i = 0; i < MAX_TUPLE; i++)
        begin : g_horner
            mtpe_horner_cell #(
                .IDX          (i),
                .MAX_TUPLE    (MAX_TUPLE),
                .ELEMENT_BITS (ELEMENT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl_in     (ctl_chain[MAX_TUPLE+i]),
                .elems_in   (elems_chain[MAX_TUPLE+i]),
                .beta_in    (beta_chain[MAX_TUPLE+i]),
                .acc_in     (acc_chain[i]),
                .pw_lo_in   (pw_lo_chain[i]),
                .pw_hi_in   (pw_hi_chain[i]),
                .pw_mix_in  (pw_mix_chain[i]),
                .ctl_out    (ctl_chain[MAX_TUPLE+i+1]),
                .elems_out  (elems_chain[MAX_TUPLE+i+1]),
                .beta_out   (beta_chain[MAX_TUPLE+i+1]),
                .acc_out    (acc_chain[i+1]),
                .pw_lo_out  (pw_lo_chain[i+1]),
                .pw_hi_out  (pw_hi_chain[i+1]),
                .pw_mix_out (pw_mix_chain[i+1])
            );
        end
    endgenerate

    // An empty tuple always encodes to zero.
    always_comb
    begin
        sum = acc_chain[MAX_TUPLE] + pw_lo_chain[MAX_TUPLE] + pw_hi_chain[MAX_TUPLE]
            - pw_mix_chain[MAX_TUPLE];
        code_next = (ctl_chain[CELLS].len == '0) ? '0 : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_chain[CELLS].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign code = code_reg;

endmodule

/* rtl/core/mtpe_max_cell.sv */
// One cell of the maximum search chain, covering a single tuple position.
module mtpe_max_cell
    import mtpe_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int MAX_TUPLE    = DEF_MAX_TUPLE,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mtpe_ctl_t                         ctl_in,
    input  logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_in,
    input  logic [ELEMENT_BITS-1:0]           beta_in,
    output mtpe_ctl_t                         ctl_out,
    output logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_out,
    output logic [ELEMENT_BITS-1:0]           beta_out
);

    logic                              vld_reg;
    logic [LEN_BITS-1:0]               len_reg;
    logic [PIVOT_BITS-1:0]             pivot_reg;
    logic [PIVOT_BITS-1:0]             pivot_next;
    logic [ELEMENT_BITS-1:0]           beta_reg;
    logic [ELEMENT_BITS-1:0]           beta_next;
    logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_reg;
    logic [ELEMENT_BITS-1:0]           elem;
    logic                              take;

    assign elem = elems_in[IDX*ELEMENT_BITS +: ELEMENT_BITS];
    assign take = (LEN_BITS'(IDX) < ctl_in.len) && (elem > beta_in);

    always_comb
    begin
        beta_next  = take ? elem : beta_in;
        pivot_next = take ? PIVOT_BITS'(IDX) : ctl_in.pivot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= ctl_in.len;
        pivot_reg <= pivot_next;
        beta_reg  <= beta_next;
        elems_reg <= elems_in;
    end

    assign ctl_out   = '{vld: vld_reg, len: len_reg, pivot: pivot_reg};
    assign elems_out = elems_reg;
    assign beta_out  = beta_reg;

endmodule

/* rtl/core/mtpe_horner_cell.sv */
// One cell of the mixed-radix accumulation chain, covering a single tuple position.
module mtpe_horner_cell
    import mtpe_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int MAX_TUPLE    = DEF_MAX_TUPLE,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mtpe_ctl_t                         ctl_in,
    input  logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_in,
    input  logic [ELEMENT_BITS-1:0]           beta_in,
    input  logic [CODE_BITS-1:0]              acc_in,
    input  logic [CODE_BITS-1:0]              pw_lo_in,
    input  logic [CODE_BITS-1:0]              pw_hi_in,
    input  logic [CODE_BITS-1:0]              pw_mix_in,
    output mtpe_ctl_t                         ctl_out,
    output logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_out,
    output logic [ELEMENT_BITS-1:0]           beta_out,
    output logic [CODE_BITS-1:0]              acc_out,
    output logic [CODE_BITS-1:0]              pw_lo_out,
    output logic [CODE_BITS-1:0]              pw_hi_out,
    output logic [CODE_BITS-1:0]              pw_mix_out
);

    localparam int BASE_BITS = ELEMENT_BITS + 1;

    logic                              vld_reg;
    logic [LEN_BITS-1:0]               len_reg;
    logic [PIVOT_BITS-1:0]             pivot_reg;
    logic [ELEMENT_BITS-1:0]           beta_reg;
    logic [MAX_TUPLE*ELEMENT_BITS-1:0] elems_reg;
    logic [CODE_BITS-1:0]              acc_reg;
    logic [CODE_BITS-1:0]              acc_next;
    logic [CODE_BITS-1:0]              pw_lo_reg;
    logic [CODE_BITS-1:0]              pw_lo_next;
    logic [CODE_BITS-1:0]              pw_hi_reg;
    logic [CODE_BITS-1:0]              pw_hi_next;
    logic [CODE_BITS-1:0]              pw_mix_reg;
    logic [CODE_BITS-1:0]              pw_mix_next;
    logic [ELEMENT_BITS-1:0]           elem;
    logic [BASE_BITS-1:0]              beta_ext;
    logic [BASE_BITS-1:0]              beta_inc;
    logic [BASE_BITS-1:0]              base;
    logic                              active;
    logic                              before_pivot;
    logic                              at_pivot;

    assign elem         = elems_in[IDX*ELEMENT_BITS +: ELEMENT_BITS];
    assign beta_ext     = BASE_BITS'(beta_in);
    assign beta_inc     = beta_ext + BASE_BITS'(1);
    assign active       = LEN_BITS'(IDX) < ctl_in.len;
    assign before_pivot = PIVOT_BITS'(IDX) < ctl_in.pivot;
    assign at_pivot     = PIVOT_BITS'(IDX) == ctl_in.pivot;
    assign base         = before_pivot ? beta_ext : beta_inc;

    // The pivot position contributes to the class offset but not to the digits.
    always_comb
    begin
        pw_lo_next  = pw_lo_in;
        pw_hi_next  = pw_hi_in;
        pw_mix_next = pw_mix_in;
        acc_next    = acc_in;
        if (active)
        begin
            pw_lo_next  = pw_lo_in * CODE_BITS'(beta_ext);
            pw_hi_next  = pw_hi_in * CODE_BITS'(beta_inc);
            pw_mix_next = pw_mix_in * CODE_BITS'(base);
            if (!at_pivot)
            begin
                acc_next = acc_in * CODE_BITS'(base) + CODE_BITS'(elem);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= ctl_in.len;
        pivot_reg  <= ctl_in.pivot;
        beta_reg   <= beta_in;
        elems_reg  <= elems_in;
        acc_reg    <= acc_next;
        pw_lo_reg  <= pw_lo_next;
        pw_hi_reg  <= pw_hi_next;
        pw_mix_reg <= pw_mix_next;
    end

    assign ctl_out    = '{vld: vld_reg, len: len_reg, pivot: pivot_reg};
    assign elems_out  = elems_reg;
    assign beta_out   = beta_reg;
    assign acc_out    = acc_reg;
    assign pw_lo_out  = pw_lo_reg;
    assign pw_hi_out  = pw_hi_reg;
    assign pw_mix_out = pw_mix_reg;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the max-based tuple pairing encoder core.
`timescale 1ns / 100ps

module tb_top;

    import mtpe_pkg::*;

    typedef logic [FIELD_COUNT-1:0][FIELD_BITS-1:0] tuple_t;

    localparam int PIPE_LATENCY = 2 * DEF_MAX_TUPLE + 1;
    localparam int ELEM_MAX     = (1 << FIELD_BITS) - 1;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [LEN_FIELD_BITS-1:0] tuple_length;
    logic [FIELD_BITS-1:0]     element_0;
    logic [FIELD_BITS-1:0]     element_1;
    logic [FIELD_BITS-1:0]     element_2;
    logic [FIELD_BITS-1:0]     element_3;
    logic                      done;
    logic [CODE_BITS-1:0]      code;

    logic [CODE_BITS-1:0] pending_codes[$];
    int                   error_count;
    int                   burst_left;

    max_tuple_pairing_encode_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tuple_length (tuple_length),
        .element_0    (element_0),
        .element_1    (element_1),
        .element_2    (element_2),
        .element_3    (element_3),
        .done         (done),
        .code         (code)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [CODE_BITS-1:0] pairing_code(input logic [LEN_FIELD_BITS-1:0] len,
                                                          input tuple_t elems);
        int          m;
        int          pivot;
        logic [63:0] beta;
        logic [63:0] acc;
        logic [63:0] pow_lo;
        logic [63:0] pow_hi;
        logic [63:0] pow_mix;
        m = (len > DEF_MAX_TUPLE) ? DEF_MAX_TUPLE : int'(len);
        if (m == 0)
        begin
            return '0;
        end
        beta  = 64'(elems[0]);
        pivot = 0;
        for (int i = 1; i < m; i++)
        begin
            if (64'(elems[i]) > beta)
            begin
                beta  = 64'(elems[i]);
                pivot = i;
            end
        end
        pow_lo  = 64'd1;
        pow_hi  = 64'd1;
        pow_mix = 64'd1;
        for (int i = 0; i < m; i++)
        begin
            pow_lo  = pow_lo * beta;
            pow_hi  = pow_hi * (beta + 64'd1);
            pow_mix = pow_mix * ((i < pivot) ? beta : beta + 64'd1);
        end
        acc = 64'd0;
        for (int i = 0; i < m; i++)
        begin
            if (i < pivot)
            begin
                acc = acc * beta + 64'(elems[i]);
            end
            else if (i > pivot)
            begin
                acc = acc * (beta + 64'd1) + 64'(elems[i]);
            end
        end
        acc = acc + pow_lo + pow_hi - pow_mix;
        return acc[CODE_BITS-1:0];
    endfunction

    // The sender alternates bursts of back-to-back requests with idle gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic issue_tuple(input logic [LEN_FIELD_BITS-1:0] len, input tuple_t elems);
        start        <= 1'b1;
        tuple_length <= len;
        element_0    <= elems[0];
        element_1    <= elems[1];
        element_2    <= elems[2];
        element_3    <= elems[3];
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_codes.push_back(pairing_code(len, elems));
        pace_sender();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_codes.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("Unexpected code %h at %0t", code, $realtime);
                end
            end
            else if (code !== pending_codes[0])
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("Code mismatch at %0t: expected %h, got %h",
                             $realtime, pending_codes[0], code);
                end
                void'(pending_codes.pop_front());
            end
            else
            begin
                void'(pending_codes.pop_front());
            end
        end
    end

    function automatic logic [FIELD_BITS-1:0] random_element();
        case ($urandom_range(0, 3))
            0: return FIELD_BITS'($urandom_range(0, 3));
            1: return FIELD_BITS'(ELEM_MAX - $urandom_range(0, 3));
            default: return FIELD_BITS'($urandom_range(0, ELEM_MAX));
        endcase
    endfunction

    task automatic test_short_lengths();
        issue_tuple(3'd0, {15'd7, 15'd9, 15'd1234, 15'h7fff});
        issue_tuple(3'd1, {15'h7fff, 15'h7fff, 15'h7fff, 15'd0});
        issue_tuple(3'd1, {15'd0, 15'd0, 15'd0, 15'h7fff});
        issue_tuple(3'd2, {15'h7fff, 15'h7fff, 15'd5, 15'd3});
        issue_tuple(3'd3, {15'h7fff, 15'd2, 15'd9, 15'd4});
    endtask

    task automatic test_saturated_lengths();
        issue_tuple(3'd5, {15'd4, 15'd3, 15'd2, 15'd1});
        issue_tuple(3'd6, {15'd1, 15'd100, 15'd100, 15'd7});
        issue_tuple(3'd7, {15'h7fff, 15'h5555, 15'h2aaa, 15'd0});
    endtask

    task automatic test_pivot_positions();
        issue_tuple(3'd4, {15'd1, 15'd2, 15'd3, 15'd50});
        issue_tuple(3'd4, {15'd1, 15'd2, 15'd50, 15'd3});
        issue_tuple(3'd4, {15'd1, 15'd50, 15'd2, 15'd3});
        issue_tuple(3'd4, {15'd50, 15'd1, 15'd2, 15'd3});
        issue_tuple(3'd4, {15'd9, 15'd9, 15'd9, 15'd9});
        issue_tuple(3'd4, {15'd9, 15'd2, 15'd9, 15'd1});
    endtask

    task automatic test_extreme_values();
        issue_tuple(3'd4, {15'd0, 15'd0, 15'd0, 15'd0});
        issue_tuple(3'd4, {15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff});
        issue_tuple(3'd4, {15'h7ffe, 15'h7fff, 15'h7ffe, 15'h7ffd});
        issue_tuple(3'd4, {15'h0001, 15'h7fff, 15'h0000, 15'h2aaa});
        issue_tuple(3'd4, {15'h5555, 15'h2aaa, 15'h5555, 15'h2aaa});
        issue_tuple(3'd3, {15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff});
    endtask

    task automatic test_random_tuples(input int count);
        tuple_t                    elems;
        logic [LEN_FIELD_BITS-1:0] len;
        int                        pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            len  = (pick < 8) ? LEN_FIELD_BITS'(pick) : LEN_FIELD_BITS'(DEF_MAX_TUPLE);
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                elems[i] = random_element();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                elems[$urandom_range(0, FIELD_COUNT - 1)] = elems[$urandom_range(0, FIELD_COUNT - 1)];
            end
            issue_tuple(len, elems);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        tuple_length = '0;
        element_0    = '0;
        element_1    = '0;
        element_2    = '0;
        element_3    = '0;
        error_count  = 0;
        burst_left   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_lengths();
        test_saturated_lengths();
        test_pivot_positions();
        test_extreme_values();
        test_random_tuples(950);

        start <= 1'b0;
        while (pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
